>>> rtl/core/gtse_pkg.sv
// Shared types and constants for the graph topological sort engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package gtse_pkg;

  localparam int unsigned NODE_W   = 5;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [STATUS_W-1:0] status_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_CONNECT    = 3'd2,
    OP_DISCONNECT = 3'd3,
    OP_SORT       = 3'd4
  } opcode_e;

  localparam status_t ST_ORDER = 2'd0;
  localparam status_t ST_CYCLE = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    edit_en;    // apply an edit request from the input
    logic    sort_clr;   // clear sort scratch counters
    logic    acc_en;     // add one source row into the in-degree counters
    logic    seed_en;    // mark every present node of in-degree zero as pending
    logic    push_en;    // append the lowest pending node to the queue
    logic    rd_en;      // read the queue at the head pointer, advance the head
    logic    apply_en;   // decrement the successors of the node just read
    logic    head_rst;   // rewind the head pointer for the emit pass
    logic    emit_load;  // load the output register with the node just read
    logic    stat_load;  // load the output register with a status-only result
    status_t stat_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic any_present;
    logic acc_last;
    logic pending_any;
    logic queue_nonempty;
    logic order_ok;
    logic emit_last;
    logic out_full;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/gtse_ctrl.sv
// Controller state machine of the topological sort engine.
// Sequences edits, the in-degree pass, Kahn's queue walk and the emit pass.
// Depends on gtse_pkg.
`default_nettype none

module gtse_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [gtse_pkg::OP_W-1:0]   in_opcode_i,
  output logic                             in_ready_o,
  input  wire gtse_pkg::sts_t              sts_i,
  output gtse_pkg::cmd_t                   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_SEED,
    S_PUSH,
    S_POPW,
    S_DONE,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMPTY,
    S_CYCLE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.stat_code = gtse_pkg::ST_ORDER;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_opcode_i == gtse_pkg::OP_SORT) begin
            if (sts_i.any_present) begin
              cmd_o.sort_clr = 1'b1;
              state_d = S_ACC;
            end else begin
              state_d = S_EMPTY;
            end
          end else begin
            cmd_o.edit_en = 1'b1;
          end
        end
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (sts_i.acc_last) begin
          state_d = S_SEED;
        end
      end
      S_SEED: begin
        cmd_o.seed_en = 1'b1;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        // Newly ready nodes go into the queue before the next pop.
        if (sts_i.pending_any) begin
          cmd_o.push_en = 1'b1;
        end else if (sts_i.queue_nonempty) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_POPW;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POPW: begin
        cmd_o.apply_en = 1'b1;
        state_d = S_PUSH;
      end
      S_DONE: begin
        cmd_o.head_rst = 1'b1;
        state_d = sts_i.order_ok ? S_EMIT_RD : S_CYCLE;
      end
      S_EMIT_RD: begin
        if (!sts_i.out_full) begin
          cmd_o.rd_en = 1'b1;
          state_d = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd_o.emit_load = 1'b1;
        state_d = sts_i.emit_last ? S_IDLE : S_EMIT_RD;
      end
      S_EMPTY: begin
        if (!sts_i.out_full) begin
          cmd_o.stat_load = 1'b1;
          cmd_o.stat_code = gtse_pkg::ST_EMPTY;
          state_d = S_IDLE;
        end
      end
      S_CYCLE: begin
        if (!sts_i.out_full) begin
          cmd_o.stat_load = 1'b1;
          cmd_o.stat_code = gtse_pkg::ST_CYCLE;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/gtse_dpath.sv
// Datapath of the topological sort engine: presence bits, adjacency rows,
// in-degree counters, the ready queue memory and the output register.
// Depends on gtse_pkg; driven by gtse_ctrl through cmd_t and sts_t.
`default_nettype none

module gtse_dpath #(
  parameter int unsigned MAX_NODES = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire gtse_pkg::cmd_t                cmd_i,
  output gtse_pkg::sts_t                     sts_o,
  input  wire logic [gtse_pkg::OP_W-1:0]     opcode_i,
  input  wire gtse_pkg::node_t               node_a_i,
  input  wire gtse_pkg::node_t               node_b_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output gtse_pkg::node_t                    out_node_o,
  output gtse_pkg::status_t                  out_status_o,
  output logic                               out_last_o
);

  localparam int unsigned IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned DW = $clog2(MAX_NODES + 1);

  localparam logic [IW-1:0] LastRow = IW'(MAX_NODES - 1);
  localparam logic [DW-1:0] DegOne  = DW'(1);

  logic [MAX_NODES-1:0] present_q;
  logic [MAX_NODES-1:0] edge_q [MAX_NODES];
  logic [DW-1:0]        deg_q [MAX_NODES];
  logic [MAX_NODES-1:0] pending_q;
  logic [IW-1:0]        row_idx_q;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        head_q;
  logic [CW-1:0]        tail_q;
  logic [IW-1:0]        queue_mem [MAX_NODES];
  logic [IW-1:0]        rd_q;

  logic                 out_valid_q;
  gtse_pkg::node_t      out_node_q;
  gtse_pkg::status_t    out_status_q;
  logic                 out_last_q;

  logic                 a_ok;
  logic                 b_ok;
  logic [IW-1:0]        a_idx;
  logic [IW-1:0]        b_idx;
  logic [IW-1:0]        push_idx;
  logic [MAX_NODES-1:0] succ_row;

  assign a_ok  = (int'(node_a_i) < MAX_NODES);
  assign b_ok  = (int'(node_b_i) < MAX_NODES);
  assign a_idx = IW'(node_a_i);
  assign b_idx = IW'(node_b_i);

  // Lowest pending node id, so ready nodes enter the queue in ascending order.
  always_comb begin
    push_idx = '0;
    for (int k = MAX_NODES - 1; k >= 0; k--) begin
      if (pending_q[k]) begin
        push_idx = IW'(k);
      end
    end
  end

  assign succ_row = edge_q[rd_q];

  // Graph edits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      for (int r = 0; r < MAX_NODES; r++) begin
        edge_q[r] <= '0;
      end
    end else if (cmd_i.edit_en) begin
      unique case (opcode_i)
        gtse_pkg::OP_ADD: begin
          if (a_ok) begin
            present_q[a_idx] <= 1'b1;
          end
        end
        gtse_pkg::OP_REMOVE: begin
          if (a_ok && present_q[a_idx]) begin
            present_q[a_idx] <= 1'b0;
            // The removed node loses its own row and its column in every other row.
            for (int r = 0; r < MAX_NODES; r++) begin
              if (IW'(r) == a_idx) begin
                edge_q[r] <= '0;
              end else begin
                edge_q[r][a_idx] <= 1'b0;
              end
            end
          end
        end
        gtse_pkg::OP_CONNECT: begin
          if (a_ok && b_ok && present_q[a_idx] && present_q[b_idx]) begin
            edge_q[a_idx][b_idx] <= 1'b1;
          end
        end
        gtse_pkg::OP_DISCONNECT: begin
          if (a_ok && b_ok) begin
            edge_q[a_idx][b_idx] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sort control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_idx_q <= '0;
      cnt_q     <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      pending_q <= '0;
    end else begin
      if (cmd_i.sort_clr) begin
        row_idx_q <= '0;
        cnt_q     <= '0;
        head_q    <= '0;
        tail_q    <= '0;
        pending_q <= '0;
      end
      if (cmd_i.acc_en) begin
        row_idx_q <= row_idx_q + IW'(1);
        cnt_q     <= cnt_q + CW'(present_q[row_idx_q]);
      end
      if (cmd_i.seed_en) begin
        for (int d = 0; d < MAX_NODES; d++) begin
          pending_q[d] <= present_q[d] && (deg_q[d] == '0);
        end
      end
      if (cmd_i.push_en) begin
        pending_q[push_idx] <= 1'b0;
        tail_q <= tail_q + CW'(1);
      end
      if (cmd_i.rd_en) begin
        head_q <= head_q + CW'(1);
      end
      if (cmd_i.head_rst) begin
        head_q <= '0;
      end
      if (cmd_i.apply_en) begin
        // A successor whose count drops to zero becomes ready.
        for (int d = 0; d < MAX_NODES; d++) begin
          pending_q[d] <= succ_row[d] && present_q[d] && (deg_q[d] == DegOne);
        end
      end
    end
  end

  // In-degree counters: one source row per cycle, then parallel decrements.
  always_ff @(posedge clk_i) begin
    for (int d = 0; d < MAX_NODES; d++) begin
      if (cmd_i.sort_clr) begin
        deg_q[d] <= '0;
      end else if (cmd_i.acc_en) begin
        if (present_q[row_idx_q] && edge_q[row_idx_q][d] && present_q[d]) begin
          deg_q[d] <= DW'(deg_q[d] + DegOne);
        end
      end else if (cmd_i.apply_en) begin
        if (succ_row[d] && present_q[d] && (deg_q[d] != '0)) begin
          deg_q[d] <= DW'(deg_q[d] - DegOne);
        end
      end
    end
  end

  // Ready queue memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_en) begin
      queue_mem[tail_q[IW-1:0]] <= push_idx;
    end
    if (cmd_i.rd_en) begin
      rd_q <= queue_mem[head_q[IW-1:0]];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load || cmd_i.stat_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_node_q   <= gtse_pkg::node_t'(rd_q);
      out_status_q <= gtse_pkg::ST_ORDER;
      out_last_q   <= (head_q == tail_q);
    end else if (cmd_i.stat_load) begin
      out_node_q   <= '0;
      out_status_q <= cmd_i.stat_code;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_node_o   = out_node_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

  assign sts_o.any_present    = |present_q;
  assign sts_o.acc_last       = (row_idx_q == LastRow);
  assign sts_o.pending_any    = |pending_q;
  assign sts_o.queue_nonempty = (head_q != tail_q);
  assign sts_o.order_ok       = (tail_q == cnt_q);
  assign sts_o.emit_last      = (head_q == tail_q);
  assign sts_o.out_full       = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/graph_topological_sort_engine_unit.sv
// Top level of the graph topological sort engine (Kahn's algorithm).
// Instantiates gtse_ctrl and gtse_dpath; depends on gtse_pkg.
//
//   Channel   Dir  tdata (low bit up)          tuser        tlast
//   s_axis    in   node_a[4:0], node_b[9:5]    opcode[2:0]  -
//   m_axis    out  node_id[4:0]                status[1:0]  last of sort
//
// Edits are applied as they are accepted. A sort accepts the request, runs the
// in-degree pass over the source rows, seeds the queue, walks it with a push, a
// pop and a decrement step per ordered node, and checks the count; emitting reads
// each result from the queue into the output register, which drains before the
// next read. An empty graph answers with a status-only result. Output stalls hold
// the sort in place. Reset clears the graph; scratch counters need no clearing.
`default_nettype none

module graph_topological_sort_engine_unit #(
  parameter int unsigned MAX_NODES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // node_a[4:0], node_b[9:5], zero pad
  input  wire logic [2:0]  s_axis_tuser_i,   // opcode[2:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // node_id[4:0], zero pad
  output logic [1:0]       m_axis_tuser_o,   // status[1:0]
  output logic             m_axis_tlast_o
);

  gtse_pkg::cmd_t    cmd;
  gtse_pkg::sts_t    sts;
  gtse_pkg::node_t   out_node;
  gtse_pkg::status_t out_status;

  gtse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_opcode_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gtse_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (s_axis_tuser_i),
    .node_a_i     (s_axis_tdata_i[4:0]),
    .node_b_i     (s_axis_tdata_i[9:5]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_node_o   (out_node),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, out_node};
  assign m_axis_tuser_o = out_status;

  // A result must never overwrite one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_load || cmd.stat_load) |-> !sts.out_full)
    else $error("output register loaded while full");

  // No sort work may run while new requests are being taken.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !(cmd.acc_en || cmd.push_en || cmd.rd_en || cmd.apply_en))
    else $error("sort activity while accepting requests");

  // A status-only result ends the sort and frees the input side.
  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.stat_load |=> s_axis_tready_o)
    else $error("sort did not end after a status result");

  // A node is read from the queue only after being pushed.
  a_pop_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> sts.queue_nonempty)
    else $error("queue read without data");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for graph_topological_sort_engine_unit: directed edits and sorts,
// then random graph-building sequences checked against an in-bench Kahn-order predictor.
// Depends on gtse_pkg and the engine RTL; reads no files.
`timescale 1ns / 100ps

module testbench;

  localparam int NODES        = 32;
  localparam int TOTAL_CMDS   = 460;
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int MAX_REPORTS  = 10;

  typedef logic [gtse_pkg::OP_W-1:0] op_t;

  // Opcodes the bus can carry beyond the defined set; the engine ignores them.
  localparam op_t OP_SPARE_FIRST = 3'd5;
  localparam op_t OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    op_t             op;
    gtse_pkg::node_t a;
    gtse_pkg::node_t b;
  } graph_cmd_t;

  typedef struct packed {
    gtse_pkg::node_t   node_id;
    gtse_pkg::status_t status;
    logic              last;
  } sort_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        req_valid = 1'b0;
  graph_cmd_t  req_cmd = '0;
  logic        req_ready;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [7:0]  res_tdata;
  logic [1:0]  res_tuser;
  logic        res_tlast;

  // Command backlog for the driver and the queue of predicted sort output.
  graph_cmd_t   cmd_backlog_q[$];
  sort_result_t expected_order_q[$];

  // Predictor copy of the graph.
  logic [NODES-1:0] graph_nodes = '0;
  logic [NODES-1:0] graph_edges [NODES];

  // Generator view of which nodes are present, and edges that break the ranking.
  logic [NODES-1:0] gen_nodes = '0;
  gtse_pkg::node_t  rank_key = '0;
  graph_cmd_t       back_edges_q[$];
  int               issued_cnt = 0;

  int accepted_cnt = 0;
  int result_cnt   = 0;
  int mismatch_cnt = 0;
  int sort_cnt     = 0;
  int ordered_cnt  = 0;
  int cycle_cnt    = 0;
  int empty_cnt    = 0;
  int clock_cnt    = 0;

  graph_topological_sort_engine_unit #(
    .MAX_NODES(NODES)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(req_valid),
    .s_axis_tready_o(req_ready),
    .s_axis_tdata_i ({6'd0, req_cmd.b, req_cmd.a}),
    .s_axis_tuser_i (req_cmd.op),
    .m_axis_tvalid_o(res_valid),
    .m_axis_tready_i(res_ready),
    .m_axis_tdata_o (res_tdata),
    .m_axis_tuser_o (res_tuser),
    .m_axis_tlast_o (res_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void expect_result(gtse_pkg::node_t id, gtse_pkg::status_t st,
                                        logic lst);
    sort_result_t r;
    r = '{node_id: id, status: st, last: lst};
    expected_order_q.insert(expected_order_q.size(), r);
  endfunction

  // Kahn's algorithm with a FIFO; seeds and successors are visited in ascending id.
  function automatic void predict_sort_order();
    logic [5:0]      indeg [NODES];
    gtse_pkg::node_t order [NODES];
    gtse_pkg::node_t n;
    int              present_cnt;
    int              head;
    int              tail;
    int              s;
    int              d;
    present_cnt = $countones(graph_nodes);
    head = 0;
    tail = 0;
    sort_cnt++;
    if (present_cnt == 0) begin
      expect_result('0, gtse_pkg::ST_EMPTY, 1'b1);
      empty_cnt++;
      return;
    end
    for (s = 0; s < NODES; s++) indeg[s] = '0;
    for (s = 0; s < NODES; s++) begin
      if (graph_nodes[s]) begin
        for (d = 0; d < NODES; d++) begin
          if (graph_edges[s][d] && graph_nodes[d]) indeg[d] = indeg[d] + 6'd1;
        end
      end
    end
    for (s = 0; s < NODES; s++) begin
      if (graph_nodes[s] && indeg[s] == 0) begin
        order[tail] = gtse_pkg::node_t'(s);
        tail++;
      end
    end
    while (head < tail) begin
      n = order[head];
      head++;
      for (d = 0; d < NODES; d++) begin
        if (graph_edges[n][d] && graph_nodes[d] && indeg[d] != 0) begin
          indeg[d] = indeg[d] - 6'd1;
          if (indeg[d] == 0) begin
            order[tail] = gtse_pkg::node_t'(d);
            tail++;
          end
        end
      end
    end
    if (tail != present_cnt) begin
      expect_result('0, gtse_pkg::ST_CYCLE, 1'b1);
      cycle_cnt++;
      return;
    end
    for (s = 0; s < tail; s++) begin
      expect_result(order[s], gtse_pkg::ST_ORDER, (s == tail - 1));
    end
    ordered_cnt += tail;
  endfunction

  function automatic void apply_graph_command(graph_cmd_t cmd);
    int i;
    case (cmd.op)
      gtse_pkg::OP_ADD: graph_nodes[cmd.a] = 1'b1;
      gtse_pkg::OP_REMOVE: begin
        if (graph_nodes[cmd.a]) begin
          graph_nodes[cmd.a] = 1'b0;
          graph_edges[cmd.a] = '0;
          for (i = 0; i < NODES; i++) graph_edges[i][cmd.a] = 1'b0;
        end
      end
      gtse_pkg::OP_CONNECT: begin
        if (graph_nodes[cmd.a] && graph_nodes[cmd.b]) graph_edges[cmd.a][cmd.b] = 1'b1;
      end
      gtse_pkg::OP_DISCONNECT: graph_edges[cmd.a][cmd.b] = 1'b0;
      gtse_pkg::OP_SORT: predict_sort_order();
      default: ;
    endcase
  endfunction

  function automatic gtse_pkg::node_t rand_node();
    return gtse_pkg::node_t'($urandom_range(0, NODES - 1));
  endfunction

  // Edges that follow the scrambled ranking can never close a cycle.
  function automatic logic rank_before(gtse_pkg::node_t x, gtse_pkg::node_t y);
    return (x ^ rank_key) < (y ^ rank_key);
  endfunction

  // Mostly a node the generator has added, now and then any slot.
  function automatic gtse_pkg::node_t pick_node();
    gtse_pkg::node_t n;
    int              tries;
    n = rand_node();
    tries = 0;
    if (gen_nodes == '0 || $urandom_range(0, 7) == 0) return n;
    while (!gen_nodes[n] && tries < 200) begin
      n = rand_node();
      tries++;
    end
    return n;
  endfunction

  task automatic push_cmd(op_t op, gtse_pkg::node_t a, gtse_pkg::node_t b);
    graph_cmd_t c;
    c = '{op: op, a: a, b: b};
    cmd_backlog_q.insert(cmd_backlog_q.size(), c);
    issued_cnt++;
    if (op == gtse_pkg::OP_ADD) gen_nodes[a] = 1'b1;
    else if (op == gtse_pkg::OP_REMOVE) gen_nodes[a] = 1'b0;
    else if (op == gtse_pkg::OP_CONNECT && !rank_before(a, b)) begin
      back_edges_q.insert(back_edges_q.size(), c);
    end
  endtask

  // Driver: bursts of requests separated by random gaps.
  int burst_left = 1;
  int gap_left   = 0;
  int taken_seen = 0;

  always @(negedge clk) begin : drive_p
    graph_cmd_t nxt;
    logic       nxt_valid;
    nxt = req_cmd;
    nxt_valid = req_valid;
    if (rst_n && (!req_valid || taken_seen != accepted_cnt)) begin
      taken_seen = accepted_cnt;
      nxt_valid = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (cmd_backlog_q.size() != 0) begin
        nxt = cmd_backlog_q.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    req_valid <= nxt_valid;
    req_cmd <= nxt;
  end

  // Receiver back-pressure: the stall pattern is redrawn from four modes whenever its run ends.
  rx_mode_e rx_mode    = RX_OPEN;
  int       mode_left  = 0;
  int       stall_run  = 0;
  int       rx_phase   = 0;

  always @(negedge clk) begin : stall_p
    logic rdy;
    if (mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 120);
    end else begin
      mode_left--;
    end
    rdy = 1'b1;
    case (rx_mode)
      RX_OPEN: rdy = 1'b1;
      RX_COIN: rdy = 1'($urandom_range(0, 1));
      RX_PERIODIC: rdy = (rx_phase % 7) < 4;
      RX_BURSTY: begin
        if (stall_run != 0) begin
          rdy = 1'b0;
          stall_run--;
        end else if ($urandom_range(0, 3) == 0) begin
          stall_run = $urandom_range(1, 12);
        end
      end
      default: ;
    endcase
    rx_phase++;
    res_ready <= rdy;
  end

  // Result checking first, then prediction for a request taken at this edge.
  always @(posedge clk) begin : check_p
    sort_result_t got;
    sort_result_t want;
    if (rst_n && res_valid && res_ready) begin
      got = '{node_id: res_tdata[gtse_pkg::NODE_W-1:0], status: res_tuser, last: res_tlast};
      result_cnt++;
      if (expected_order_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("unexpected result: node %0d status %0d last %0d",
                   got.node_id, got.status, got.last);
        end
      end else begin
        want = expected_order_q.pop_front();
        if (got.node_id !== want.node_id || got.status !== want.status ||
            got.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("result %0d: expected node %0d status %0d last %0d,",
                     result_cnt, want.node_id, want.status, want.last);
            $display("  got node %0d status %0d last %0d",
                     got.node_id, got.status, got.last);
          end
        end
      end
    end
    if (rst_n && req_valid && req_ready) begin
      apply_graph_command(req_cmd);
      accepted_cnt++;
    end
  end

  always @(posedge clk) begin : watchdog_p
    clock_cnt++;
    if (clock_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d predicted results outstanding",
               clock_cnt, expected_order_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus_p
    graph_cmd_t      e;
    gtse_pkg::node_t x;
    gtse_pkg::node_t y;
    gtse_pkg::node_t base;
    int              pick;
    int              i;
    for (i = 0; i < NODES; i++) graph_edges[i] = '0;
    rank_key = rand_node();

    // Directed part: empty graph, slot extremes, duplicates, ignored edits,
    // spare opcodes, a self loop, and removal down to an empty graph.
    push_cmd(gtse_pkg::OP_SORT, rand_node(), rand_node());
    push_cmd(gtse_pkg::OP_ADD, 5'd0, rand_node());
    push_cmd(gtse_pkg::OP_ADD, 5'd31, rand_node());
    push_cmd(gtse_pkg::OP_ADD, 5'd31, rand_node());
    push_cmd(gtse_pkg::OP_CONNECT, 5'd31, 5'd0);
    push_cmd(gtse_pkg::OP_CONNECT, 5'd31, 5'd0);
    push_cmd(gtse_pkg::OP_CONNECT, 5'd0, 5'd5);
    push_cmd(gtse_pkg::OP_SORT, rand_node(), rand_node());
    for (i = OP_SPARE_FIRST; i <= OP_SPARE_LAST; i++) begin
      push_cmd(op_t'(i), rand_node(), rand_node());
    end
    push_cmd(gtse_pkg::OP_CONNECT, 5'd0, 5'd0);
    push_cmd(gtse_pkg::OP_SORT, rand_node(), rand_node());
    push_cmd(gtse_pkg::OP_DISCONNECT, 5'd0, 5'd0);
    push_cmd(gtse_pkg::OP_DISCONNECT, 5'd7, 5'd9);
    push_cmd(gtse_pkg::OP_SORT, rand_node(), rand_node());
    push_cmd(gtse_pkg::OP_REMOVE, 5'd5, rand_node());
    push_cmd(gtse_pkg::OP_REMOVE, 5'd31, rand_node());
    push_cmd(gtse_pkg::OP_SORT, rand_node(), rand_node());
    push_cmd(gtse_pkg::OP_REMOVE, 5'd0, rand_node());
    push_cmd(gtse_pkg::OP_SORT, rand_node(), rand_node());
    back_edges_q.delete();

    // Random part: mostly graph building followed by a sort, with the odd
    // full wipe and short runs of arbitrary requests.
    while (issued_cnt < TOTAL_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        base = rand_node();
        for (i = 0; i < NODES; i++) begin
          push_cmd(gtse_pkg::OP_REMOVE, gtse_pkg::node_t'(base + i), rand_node());
        end
        push_cmd(gtse_pkg::OP_SORT, rand_node(), rand_node());
      end else if (pick < 80) begin
        if ($urandom_range(0, 4) != 0) begin
          while (back_edges_q.size() != 0) begin
            e = back_edges_q.pop_front();
            push_cmd(gtse_pkg::OP_DISCONNECT, e.a, e.b);
          end
        end
        repeat ($urandom_range(0, 3)) push_cmd(gtse_pkg::OP_REMOVE, pick_node(), rand_node());
        repeat ($urandom_range(1, 6)) push_cmd(gtse_pkg::OP_ADD, rand_node(), rand_node());
        repeat ($urandom_range(0, 8)) begin
          x = pick_node();
          y = pick_node();
          if (x == y) y = x ^ 5'd1;
          if (rank_before(x, y)) push_cmd(gtse_pkg::OP_CONNECT, x, y);
          else push_cmd(gtse_pkg::OP_CONNECT, y, x);
        end
        if ($urandom_range(0, 6) == 0) begin
          x = pick_node();
          y = ($urandom_range(0, 2) == 0) ? x : pick_node();
          if (rank_before(x, y)) push_cmd(gtse_pkg::OP_CONNECT, y, x);
          else push_cmd(gtse_pkg::OP_CONNECT, x, y);
        end
        push_cmd(gtse_pkg::OP_SORT, rand_node(), rand_node());
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_cmd(op_t'($urandom_range(0, OP_SPARE_LAST)), rand_node(), rand_node());
        end
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog_q.size() != 0 || req_valid) @(negedge clk);
    while (expected_order_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d requests accepted, %0d sorts: %0d ordered nodes, %0d cyclic, %0d empty",
             accepted_cnt, sort_cnt, ordered_cnt, cycle_cnt, empty_cnt);
    $display("%0d results checked, %0d mismatches", result_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
